[rtl/core/trq_pkg.sv]
`timescale 1ns / 1ps

package trq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TASK_W = 64;

	localparam logic [1:0] OP_PUT  = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_GRAB = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [TASK_W-1:0] task_value;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [TASK_W-1:0] task_out;
		logic [5:0]        grab_total;
		logic              last;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic put;
		logic pop;
		logic grab;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic grab_last;
	} ctrl_sts_t;

endpackage

[rtl/core/trq_ctrl.sv]
`timescale 1ns / 1ps

module trq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          operation,
	input  trq_pkg::ctrl_sts_t  sts,
	output trq_pkg::ctrl_cmd_t  cmd,
	output logic                busy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PUT  = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_GRAB = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (operation)
						trq_pkg::OP_PUT:  state_d = S_PUT;
						trq_pkg::OP_POP:  state_d = S_POP;
						trq_pkg::OP_GRAB: state_d = S_GRAB;
						default:          state_d = S_IDLE;
					endcase
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_IDLE;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_IDLE;
			end
			S_GRAB: begin
				cmd.grab = 1'b1;
				if (sts.empty || sts.grab_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.put, cmd.pop, cmd.grab}))
		else $error("more than one datapath command at once");

	a_grab_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GRAB && (sts.empty || sts.grab_last)) |=> !busy)
		else $error("grab did not end after its last word");

endmodule

[rtl/core/trq_dp.sv]
`timescale 1ns / 1ps

module trq_dp #(
	parameter int QUEUE_DEPTH = trq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  trq_pkg::req_t       req,
	input  trq_pkg::ctrl_cmd_t  cmd,
	output trq_pkg::ctrl_sts_t  sts,
	output logic                done,
	output trq_pkg::rsp_t       result
);

	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LVL_WP = LVL_W + 1;

	logic [trq_pkg::TASK_W-1:0] mem_q [QUEUE_DEPTH];
	logic [trq_pkg::TASK_W-1:0] rdata_q;
	logic [trq_pkg::TASK_W-1:0] task_q;

	logic [SLOT_W-1:0] head_slot_q, tail_slot_q;
	logic              head_wrap_q, tail_wrap_q;
	logic [SLOT_W-1:0] head_slot_inc, tail_slot_inc;
	logic [SLOT_W-1:0] head_slot_d;
	logic              head_adv, tail_adv;

	logic [LVL_WP-1:0] lvl_wide;
	logic [LVL_WP-1:0] half_wide;
	logic [LVL_W-1:0]  level;
	logic [LVL_W-1:0]  n_q;
	logic [LVL_W-1:0]  cnt_q;
	logic              full, empty, grab_last;

	logic              done_q;
	trq_pkg::rsp_t     rsp_d, rsp_q;
	logic              emit;

	always_comb begin
		lvl_wide = LVL_WP'(tail_slot_q) - LVL_WP'(head_slot_q);
		if (tail_wrap_q != head_wrap_q) begin
			lvl_wide = lvl_wide + LVL_WP'(QUEUE_DEPTH);
		end
		level = lvl_wide[LVL_W-1:0];
		half_wide = (LVL_WP'(level) + LVL_WP'(1)) >> 1;
	end

	assign full = (level == LVL_W'(QUEUE_DEPTH));
	assign empty = (level == '0);
	assign grab_last = (cnt_q == n_q - LVL_W'(1));

	assign sts.empty = empty;
	assign sts.grab_last = grab_last;

	assign head_slot_inc = (head_slot_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_slot_q + SLOT_W'(1);
	assign tail_slot_inc = (tail_slot_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_slot_q + SLOT_W'(1);

	assign head_adv = (cmd.pop || cmd.grab) && !empty;
	assign tail_adv = cmd.put && !full;
	// read port tracks the head as it will be next cycle
	assign head_slot_d = head_adv ? head_slot_inc : head_slot_q;

	always_comb begin
		emit = cmd.put || cmd.pop || cmd.grab;
		rsp_d = '0;
		rsp_d.last = 1'b1;
		if (cmd.put) begin
			rsp_d.status = full ? trq_pkg::ST_FULL : trq_pkg::ST_OK;
		end else if (empty) begin
			rsp_d.status = trq_pkg::ST_EMPTY;
		end else begin
			rsp_d.status = trq_pkg::ST_OK;
			rsp_d.task_out = rdata_q;
			if (cmd.grab) begin
				rsp_d.grab_total = 6'(n_q);
				rsp_d.last = grab_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_adv) begin
			mem_q[tail_slot_q] <= task_q;
		end
		rdata_q <= mem_q[head_slot_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot_q <= '0;
			head_wrap_q <= 1'b0;
			tail_slot_q <= '0;
			tail_wrap_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
			if (head_adv) begin
				head_slot_q <= head_slot_inc;
				if (head_slot_q == SLOT_W'(QUEUE_DEPTH - 1)) begin
					head_wrap_q <= !head_wrap_q;
				end
			end
			if (tail_adv) begin
				tail_slot_q <= tail_slot_inc;
				if (tail_slot_q == SLOT_W'(QUEUE_DEPTH - 1)) begin
					tail_wrap_q <= !tail_wrap_q;
				end
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.grab) begin
				cnt_q <= cnt_q + LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			task_q <= req.task_value;
			n_q <= half_wide[LVL_W-1:0];
		end
		rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign result = rsp_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LVL_W'(QUEUE_DEPTH))
		else $error("fill level beyond queue depth");

	a_full_put_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put && full) |=> ($stable(tail_slot_q) && $stable(tail_wrap_q)))
		else $error("tail moved on a refused put");

	a_grab_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !rsp_q.last) |=> done_q)
		else $error("grab burst broken before its last word");

endmodule

[rtl/core/task_ring_queue_with_grab_half_top.sv]
`timescale 1ns / 1ps

// channel   ports                  handshake
// request   start, busy, req       word taken when start && !busy
// result    done, result           word on the ports for one cycle while done is high
//
// put and pop: after the accept edge busy stays high through the work state; result the cycle after.
// grab of n tasks: busy while in the grab work state, n result words back to back, each one registered.
// a new word can be taken in the cycle of the last result; code 3 is taken and gives nothing.
// the slot memory read is registered, so the head word is fetched ahead, from the next head slot.
// arst_n clears head, tail and control; slot contents are undefined until written.
// the receiver cannot stall: each result word is taken the cycle it appears.
module task_ring_queue_with_grab_half_top #(
	parameter int QUEUE_DEPTH = trq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  trq_pkg::req_t req,
	output logic          done,
	output trq_pkg::rsp_t result
);

	trq_pkg::ctrl_cmd_t cmd;
	trq_pkg::ctrl_sts_t sts;

	trq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (req.operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	trq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule
